[design/signed_int_to_decimal_ascii_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text unit
// Shared property wrappers, all clocked on the rising edge and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SITDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("signed-to-decimal text check failed");

// The consequent must hold in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("signed-to-decimal text check failed");

`endif

[design/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Constants and types shared by the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

	localparam int CHAR_W = 8;
	localparam int LEN_W  = 4;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} back_state_t;

endpackage

`default_nettype wire

[design/sitda_stream_if.sv]
// ----------------------------------------------------------------------------
// sitda stream interfaces
// Valid/ready channels for the integer operand and for the text characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface sitda_value_if #(parameter int VALUE_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sitda_text_if;
	logic                             valid;
	logic                             ready;
	logic [sitda_pkg::CHAR_W-1:0]     character;
	logic [sitda_pkg::LEN_W-1:0]      text_length;
	logic                             last;

	modport source (output valid, output character, output text_length, output last,
		input ready);
	modport sink   (input valid, input character, input text_length, input last,
		output ready);
endinterface

`default_nettype wire

[design/sitda_front.sv]
// ----------------------------------------------------------------------------
// sitda_front
// Accepts operands, splits each into a sign flag and an unsigned magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_front #(
	parameter int VALUE_WIDTH = 32
) (
	sitda_value_if.sink              num,
	output logic                     push_valid,
	input  wire logic                push_ready,
	output logic [VALUE_WIDTH:0]     push_data
);

	logic                   negative;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] magnitude;

	assign raw      = num.value;
	assign negative = raw[VALUE_WIDTH-1];

	// The magnitude is kept unsigned and one bit wider in meaning than the
	// signed range, so the most negative value maps to 2^(VALUE_WIDTH-1).
	assign magnitude = negative ? (~raw + VALUE_WIDTH'(1)) : raw;

	assign push_valid = num.valid;
	assign num.ready  = push_ready;
	assign push_data  = {negative, magnitude};

endmodule

`default_nettype wire

[design/sitda_queue.sv]
// ----------------------------------------------------------------------------
// sitda_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_queue #(
	parameter int DATA_WIDTH = 33
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push_valid,
	output logic                       push_ready,
	input  wire logic [DATA_WIDTH-1:0] push_data,
	output logic                       pop_valid,
	input  wire logic                  pop_ready,
	output logic [DATA_WIDTH-1:0]      pop_data
);

	localparam int PW = $clog2(sitda_pkg::QUEUE_DEPTH);

	logic [DATA_WIDTH-1:0] entry_q [sitda_pkg::QUEUE_DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [PW:0]           count_q;
	logic                  push;
	logic                  pop;

	assign push_ready = (count_q != (PW+1)'(sitda_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[design/sitda_back.sv]
// ----------------------------------------------------------------------------
// sitda_back
// Bit-serial binary to BCD converter followed by a character emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pop_valid,
	output logic                      pop_ready,
	input  wire logic [VALUE_WIDTH:0] pop_data,
	sitda_text_if.source              text
);

	// Enough decimal digits for 2^(VALUE_WIDTH-1) over the whole parameter range.
	localparam int NDIG = (VALUE_WIDTH * 3) / 10 + 1;
	localparam int DIW  = $clog2(NDIG);
	localparam int CW   = $clog2(NDIG + 1);
	localparam int SW   = $clog2(VALUE_WIDTH);
	localparam int LW   = (CW + 1 > sitda_pkg::LEN_W) ? CW + 1 : sitda_pkg::LEN_W;

	sitda_pkg::back_state_t state_q;
	sitda_pkg::back_state_t state_d;

	logic [VALUE_WIDTH-1:0]       bin_q;
	logic [4*NDIG-1:0]            bcd_q;
	logic [CW-1:0]                ndig_q;
	logic [SW-1:0]                step_q;
	logic                         neg_q;
	logic                         minus_pend_q;
	logic [DIW-1:0]               didx_q;
	logic [sitda_pkg::LEN_W-1:0]  len_q;

	logic [4*NDIG-1:0]            adj;
	logic [4*NDIG-1:0]            nbcd;
	logic [VALUE_WIDTH-1:0]       nbin;
	logic                         grow;
	logic [CW-1:0]                ndig_next;
	logic [LW-1:0]                len_sum;
	logic [3:0]                   cur_digit;
	logic                         last_step;
	logic                         emit_fire;

	// One shift-and-add-3 step: every digit of five or more gets three added
	// before the whole BCD and binary word shifts left by one bit.
	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
		nbcd = {adj[4*NDIG-2:0], bin_q[VALUE_WIDTH-1]};
		nbin = {bin_q[VALUE_WIDTH-2:0], 1'b0};
	end

	// The value at most doubles per step, so the significant digit count
	// grows by at most one: only the digit just above the current top is
	// examined.
	assign grow      = (ndig_q < CW'(NDIG)) && (nbcd[4*ndig_q[DIW-1:0] +: 4] != 4'd0);
	assign ndig_next = ndig_q + CW'(grow);
	assign len_sum   = LW'(ndig_next) + LW'(neg_q);
	assign last_step = (step_q == SW'(VALUE_WIDTH - 1));

	assign cur_digit = bcd_q[4*didx_q +: 4];
	assign emit_fire = text.valid && text.ready;

	assign pop_ready        = (state_q == sitda_pkg::ST_IDLE);
	assign text.valid       = (state_q == sitda_pkg::ST_EMIT);
	assign text.character   = minus_pend_q ? sitda_pkg::ASCII_MINUS
		: (sitda_pkg::ASCII_ZERO + {4'b0000, cur_digit});
	assign text.text_length = len_q;
	assign text.last        = !minus_pend_q && (didx_q == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sitda_pkg::ST_IDLE: begin
				if (pop_valid) begin
					state_d = sitda_pkg::ST_CONV;
				end
			end
			sitda_pkg::ST_CONV: begin
				if (last_step) begin
					state_d = sitda_pkg::ST_EMIT;
				end
			end
			sitda_pkg::ST_EMIT: begin
				if (emit_fire && text.last) begin
					state_d = sitda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sitda_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sitda_pkg::ST_IDLE) begin
			neg_q  <= pop_data[VALUE_WIDTH];
			bin_q  <= pop_data[VALUE_WIDTH-1:0];
			bcd_q  <= '0;
			ndig_q <= CW'(1);
			step_q <= '0;
		end else if (state_q == sitda_pkg::ST_CONV) begin
			bin_q  <= nbin;
			bcd_q  <= nbcd;
			ndig_q <= ndig_next;
			step_q <= step_q + SW'(1);
			if (last_step) begin
				minus_pend_q <= neg_q;
				didx_q       <= DIW'(ndig_next - CW'(1));
				len_q        <= len_sum[sitda_pkg::LEN_W-1:0];
			end
		end else if (emit_fire) begin
			if (minus_pend_q) begin
				minus_pend_q <= 1'b0;
			end else if (didx_q != '0) begin
				didx_q <= didx_q - DIW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[design/signed_int_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed VALUE_WIDTH-bit integer to its decimal ASCII text, one
// character per transaction, most significant first: a leading '-' for
// negative values, a single '0' for zero, no leading zeros, and the most
// negative value printed from its unsigned magnitude. Every character carries
// the total text length and a flag on the final one. Each value is first
// loaded, then converted one magnitude bit per cycle in the shift-and-add-3
// binary to BCD converter, then emitted one character per cycle while the
// output is not stalled. The converter handles one value at a time; a
// two-entry queue in front of it takes new operands while a text is still
// being converted or emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input wire logic     clk,
	input wire logic     arst_n,
	sitda_value_if.sink  num,
	sitda_text_if.source text
);

	logic                 push_valid;
	logic                 push_ready;
	logic [VALUE_WIDTH:0] push_data;
	logic                 pop_valid;
	logic                 pop_ready;
	logic [VALUE_WIDTH:0] pop_data;

	sitda_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.num        (num),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sitda_queue #(
		.DATA_WIDTH (VALUE_WIDTH + 1)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sitda_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.text      (text)
	);

endmodule

`default_nettype wire

[design/sitda_checker.sv]
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks on the text channel of the decimal text unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sitda_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            text_valid,
	input wire logic                            text_ready,
	input wire logic [sitda_pkg::CHAR_W-1:0]    text_character,
	input wire logic [sitda_pkg::LEN_W-1:0]     text_text_length,
	input wire logic                            text_last
);

	// A stalled character stays on the channel unchanged.
	`SITDA_ASSERT_NEXT(a_stall_holds, clk, arst_n, text_valid && !text_ready, text_valid && $stable(text_character) && $stable(text_text_length) && $stable(text_last))

	// Only a minus sign or a decimal digit is ever sent.
	`SITDA_ASSERT_SAME(a_char_legal, clk, arst_n, text_valid, (text_character == sitda_pkg::ASCII_MINUS) || ((text_character >= sitda_pkg::ASCII_ZERO) && (text_character <= sitda_pkg::ASCII_NINE)))

	// The sign always precedes at least one digit.
	`SITDA_ASSERT_SAME(a_minus_not_last, clk, arst_n, text_valid && (text_character == sitda_pkg::ASCII_MINUS), !text_last)

	// Within one text the reported length does not change.
	`SITDA_ASSERT_NEXT(a_length_steady, clk, arst_n, text_valid && text_ready && !text_last, !text_valid || (text_text_length == $past(text_text_length)))

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.text_valid       (text.valid),
	.text_ready       (text.ready),
	.text_character   (text.character),
	.text_text_length (text.text_length),
	.text_last        (text.last)
);

`default_nettype wire
